// ----- src/anr_pkg.sv -----
// shared types and constants of the nearest-neighbor audio resampler
// no dependencies; imported by every module of the block
package anr_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int STEP_W    = 16;
    localparam int TOTAL_W   = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 24;
    localparam int MAX_RES   = 64;
    localparam int RES_CNT_W = $clog2(MAX_RES) + 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAC_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IN_WIDE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_TOTAL = 2'd3;

    localparam logic [STEP_W-1:0] FRAC_STEP_RST = 16'd256;

    typedef struct packed {
        logic [STEP_W-1:0]  frac_step;
        logic               in_wide;
        logic               out_wide;
        logic [TOTAL_W-1:0] out_total;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic load;     // take a new source sample
        logic step;     // produce one result into the pending slot
        logic push;     // move the pending result to the output register
        logic finish;   // pending result is the last one, advance source index
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic due;        // another result falls on the current sample
        logic pend_valid; // a result waits in the pending slot
        logic out_free;   // output register can take a result this cycle
    } status_t;

endpackage

// ----- src/anr_ctrl.sv -----
// controller state machine of the resampler
// depends on anr_pkg
module anr_ctrl import anr_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t status,
    output cmd_t    cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic state_reg;
    logic state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (status.pend_valid && !status.out_free) begin
                    // wait for the output register
                end else if (status.due) begin
                    cmd.step = 1'b1;
                    cmd.push = status.pend_valid;
                end else begin
                    cmd.finish = 1'b1;
                    cmd.push   = status.pend_valid;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- src/anr_dp.sv -----
// datapath of the resampler: counters, pending result and output register
// depends on anr_pkg
module anr_dp import anr_pkg::*; #(
    parameter int COUNT_BITS = 24
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cfg_t                cfg,
    input  cmd_t                cmd,
    output status_t             status,
    input  logic [SAMPLE_W-1:0] sample_raw,
    input  logic                first,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [SAMPLE_W-1:0] sample_out,
    output logic                run_last,
    output logic                sound_done
);

    localparam int ACC_W = COUNT_BITS + 8;
    localparam int LIM_W = (COUNT_BITS > TOTAL_W) ? COUNT_BITS : TOTAL_W;

    logic [COUNT_BITS-1:0] src_idx_reg;
    logic [ACC_W-1:0]      pos_acc_reg;
    logic [COUNT_BITS-1:0] emit_cnt_reg;
    logic [RES_CNT_W-1:0]  res_cnt_reg;
    logic [SAMPLE_W-1:0]   word_reg;
    logic                  pend_valid_reg;
    logic [SAMPLE_W-1:0]   pend_word_reg;
    logic                  pend_done_reg;
    logic                  out_valid_reg;
    logic [SAMPLE_W-1:0]   out_word_reg;
    logic                  out_last_reg;
    logic                  out_done_reg;

    logic [SAMPLE_W-1:0]   wide_in;
    logic [SAMPLE_W-1:0]   word_next;
    logic [LIM_W-1:0]      total_ext;
    logic [LIM_W-1:0]      mask_ext;
    logic [COUNT_BITS-1:0] limit;
    logic [COUNT_BITS-1:0] lag_dist;
    logic [COUNT_BITS-1:0] emit_inc;
    logic [ACC_W-1:0]      pos_next;

    // 8-bit input: recenter and move to the high byte
    assign wide_in   = cfg.in_wide ? sample_raw : {~sample_raw[7], sample_raw[6:0], 8'h00};
    // 8-bit output: arithmetic shift right by 8
    assign word_next = cfg.out_wide ? wide_in : {{8{wide_in[15]}}, wide_in[15:8]};

    assign total_ext = LIM_W'(cfg.out_total);
    assign mask_ext  = LIM_W'({COUNT_BITS{1'b1}});
    assign limit     = (total_ext < mask_ext) ? total_ext[COUNT_BITS-1:0]
                                              : {COUNT_BITS{1'b1}};

    // output is due when its position is at or behind the source index
    assign lag_dist = src_idx_reg - pos_acc_reg[ACC_W-1:8];
    assign emit_inc = emit_cnt_reg + 1'b1;
    assign pos_next = pos_acc_reg + ACC_W'(cfg.frac_step);

    assign status.due        = (emit_cnt_reg < limit) && !lag_dist[COUNT_BITS-1]
                               && !res_cnt_reg[RES_CNT_W-1];
    assign status.pend_valid = pend_valid_reg;
    assign status.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid   = out_valid_reg;
    assign sample_out = out_word_reg;
    assign run_last   = out_last_reg;
    assign sound_done = out_done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_idx_reg    <= '0;
            pos_acc_reg    <= '0;
            emit_cnt_reg   <= '0;
            res_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd.load) begin
                res_cnt_reg <= '0;
                if (first) begin
                    src_idx_reg  <= '0;
                    pos_acc_reg  <= '0;
                    emit_cnt_reg <= '0;
                end
            end
            if (cmd.step) begin
                emit_cnt_reg   <= emit_inc;
                pos_acc_reg    <= pos_next;
                res_cnt_reg    <= res_cnt_reg + 1'b1;
                pend_valid_reg <= 1'b1;
            end
            if (cmd.finish) begin
                src_idx_reg    <= src_idx_reg + 1'b1;
                pend_valid_reg <= 1'b0;
            end
            if (cmd.push) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            word_reg <= word_next;
        end
        if (cmd.step) begin
            pend_word_reg <= word_reg;
            pend_done_reg <= (emit_inc >= limit);
        end
        if (cmd.push) begin
            out_word_reg <= pend_word_reg;
            out_done_reg <= pend_done_reg;
            out_last_reg <= cmd.finish;
        end
    end

endmodule

// ----- src/audio_nearest_resampler_top.sv -----
// top level of the nearest-neighbor audio resampler with an 8.8 fixed step
// depends on anr_pkg, anr_ctrl and anr_dp
//
// usage
// - slave stream: one source sample per transfer, s_tdata[15:0] raw bits
//   (low byte unsigned in 8-bit mode), s_tuser set on the first sample of a
//   sound to clear the source index, position and output count
// - master stream: zero or more results per source sample; m_tdata[15:0]
//   signed sample, m_tlast on the last result of that source sample,
//   m_tuser on the result that completes the sound's output count
// - config: write cfg_data to register cfg_index while cfg_wr_en is high,
//   only while the block is idle; 0 frac_step, 1 in_wide, 2 out_wide,
//   3 out_total
// - timing: a sample holds the slave side until all its results are made,
//   also when it makes none; each result passes through the pending slot
//   to the output register, one result per cycle while the receiver keeps
//   up, set by the single counter update loop in the datapath
// - at most 64 results per sample; leftover results follow later samples
// - a stalled receiver holds the output register, one more result waits in
//   the pending slot, then the controller pauses
// - reset (aresetn low, synchronous) clears counters, handshakes and
//   restores the configuration defaults
module audio_nearest_resampler_top import anr_pkg::*; #(
    parameter int COUNT_BITS = 24
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    // source samples
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // [15:0] sample_raw
    input  logic                 s_tuser,   // [0] first
    // resampled output
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // [15:0] sample_out
    output logic                 m_tlast,   // run_last
    output logic                 m_tuser    // [0] sound_done
);

    cfg_t    cfg_reg;
    cmd_t    cmd;
    status_t status;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frac_step <= FRAC_STEP_RST;
            cfg_reg.in_wide   <= 1'b0;
            cfg_reg.out_wide  <= 1'b0;
            cfg_reg.out_total <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_FRAC_STEP: cfg_reg.frac_step <= cfg_data[STEP_W-1:0];
                REG_IN_WIDE:   cfg_reg.in_wide   <= cfg_data[0];
                REG_OUT_WIDE:  cfg_reg.out_wide  <= cfg_data[0];
                REG_OUT_TOTAL: cfg_reg.out_total <= cfg_data[TOTAL_W-1:0];
            endcase
        end
    end

    // sequencing of load, result steps and finish
    anr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // counters, lag compare, pending slot and output register
    anr_dp #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .cmd        (cmd),
        .status     (status),
        .sample_raw (s_tdata),
        .first      (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .sample_out (m_tdata),
        .run_last   (m_tlast),
        .sound_done (m_tuser)
    );

    // no pending result while the slave side is open
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !status.pend_valid)
        else $error("pending result while idle");

    // a result is only moved when the output register can take it
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> status.out_free)
        else $error("output register overwritten");

    // finishing a sample reopens the slave side
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> s_tready)
        else $error("slave side not reopened after finish");

    // a new sample is never taken with a result still pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> !status.pend_valid)
        else $error("pending result left over at load");

endmodule

// ----- sim/tb_audio_nearest_resampler_top.sv -----
`timescale 1ns / 1ps
// self-checking testbench of audio_nearest_resampler_top: a directed table, then random phases
// depends on anr_pkg and the resampler rtl; predicts every output sample in its own code
module tb_audio_nearest_resampler_top import anr_pkg::*; ();

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 12;
    localparam int SETTLE_CYC   = 8;     // a sample without results still holds the block
    localparam int END_CYCLES   = 20;
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off, fills the block
    localparam int STALL_LIMIT  = 2000;  // cycles without any transfer before giving up
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 38;
    localparam int HOLD_PHASE   = 1;
    localparam int MAX_REPORTS  = 40;

    // one expected output transfer
    typedef struct packed {
        logic [15:0] sample;
        logic        run_last;
        logic        sound_done;
    } out_sample_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    // directed row: a register write, or a source sample with an optional hand-typed output
    typedef struct packed {
        row_kind_t          kind;
        logic [1:0]         reg_idx;
        logic [23:0]        value;        // register data, or the raw sample in [15:0]
        logic               first;
        logic               typed;
        logic [15:0]        typed_sample;
    } dir_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [15:0]          s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [15:0]          m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;

    // predictor copy of the registers, reset values
    logic [15:0] cfg_step     = FRAC_STEP_RST;
    logic        cfg_in_wide  = 1'b0;
    logic        cfg_out_wide = 1'b0;
    logic [23:0] cfg_total    = '0;

    // predictor copy of the counters
    logic [23:0] src_index = '0;
    logic [31:0] out_pos   = '0;   // 24.8 position of the next output in source samples
    logic [23:0] out_count = '0;

    out_sample_t pending_outputs[$];   // outputs predicted but not yet seen
    dir_row_t    dir_rows[$];

    int  mismatch_count = 0;
    int  result_count   = 0;
    int  idle_cycles    = 0;
    int  burst_left[2]  = '{0, 0};     // per side: transfers left in a stretch without idling
    bit  hold_req       = 1'b0;
    bit  items_since_idle = 1'b0;

    audio_nearest_resampler_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    // side 0 is the sender, side 1 the receiver
    function automatic int draw_gap(input int side);
        if (burst_left[side] > 0) begin
            burst_left[side] -= 1;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            burst_left[side] = $urandom_range(8, 30);
            return 0;
        end
        return $urandom_range(0, 6);
    endfunction

    function automatic void apply_reg(input logic [1:0] idx, input logic [23:0] value);
        case (idx)
            REG_FRAC_STEP: begin
                cfg_step = value[15:0];
            end
            REG_IN_WIDE: begin
                cfg_in_wide = value[0];
            end
            REG_OUT_WIDE: begin
                cfg_out_wide = value[0];
            end
            REG_OUT_TOTAL: begin
                cfg_total = value;
            end
            default: begin
            end
        endcase
    endfunction

    // emit every output whose position falls at or behind the current source sample,
    // at most MAX_RES of them, until the sound's output total is reached
    function automatic void resample_source(input logic first, input logic [15:0] raw,
                                            input logic typed, input logic [15:0] typed_sample);
        logic [15:0] widened;
        logic [15:0] word;
        logic [23:0] lag;
        out_sample_t r;
        bit          have_r;
        int          n;
        n = 0;
        have_r = 1'b0;
        r = '0;
        if (first) begin
            src_index = '0;
            out_pos   = '0;
            out_count = '0;
        end
        // 8-bit input: unsigned low byte recentred, moved to the top byte
        widened = cfg_in_wide ? raw : {raw[7:0] ^ 8'h80, 8'h00};
        // 8-bit output: arithmetic shift right by 8
        word = cfg_out_wide ? widened : {{8{widened[15]}}, widened[15:8]};
        if (typed) begin
            word = typed_sample;
        end
        // due while the output position is not ahead of the source, modulo the counter range
        lag = src_index - out_pos[31:8];
        while (n < MAX_RES && out_count < cfg_total && !lag[23]) begin
            if (have_r) begin
                pending_outputs.push_back(r);
            end
            out_count += 24'd1;
            out_pos   += {16'd0, cfg_step};
            r.sample     = word;
            r.run_last   = 1'b0;
            r.sound_done = (out_count >= cfg_total);
            have_r = 1'b1;
            n++;
            lag = src_index - out_pos[31:8];
        end
        if (have_r) begin
            r.run_last = 1'b1;
            pending_outputs.push_back(r);
        end
        src_index += 24'd1;
    endfunction

    function automatic void add_cfg(input logic [1:0] idx, input logic [23:0] value);
        dir_rows.push_back('{ROW_CFG, idx, value, 1'b0, 1'b0, 16'd0});
    endfunction

    function automatic void add_item(input logic first, input logic [15:0] raw,
                                     input logic typed, input logic [15:0] typed_sample);
        dir_rows.push_back('{ROW_ITEM, 2'd0, {8'd0, raw}, first, typed, typed_sample});
    endfunction

    // register write, one per clock; the next sample transfer lowers the enable
    task automatic write_reg(input logic [1:0] idx, input logic [23:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        apply_reg(idx, value);
    endtask

    // one source sample transfer after a random gap; predicts its outputs on acceptance
    task automatic send_item(input logic first, input logic [15:0] raw,
                             input logic typed, input logic [15:0] typed_sample);
        int gap;
        gap = draw_gap(0);
        cfg_wr_en <= 1'b0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= raw;
        s_tuser  <= first;
        do @(posedge aclk); while (!s_tready);
        resample_source(first, raw, typed, typed_sample);
        items_since_idle = 1'b1;
    endtask

    // all predicted outputs seen, then a settling wait for a sample that made none
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
        items_since_idle = 1'b0;
    endtask

    // directed table
    initial begin
        // reset defaults: out_total is zero, nothing comes out
        add_item(1'b1, 16'h00FF, 1'b0, 16'h0000);
        add_item(1'b0, 16'h1234, 1'b0, 16'h0000);
        // 8-bit in, 8-bit out, unit step, short sound: extremes and sound complete
        add_cfg(REG_OUT_TOTAL, 24'd6);
        add_item(1'b1, 16'h0000, 1'b1, 16'hFF80);
        add_item(1'b0, 16'h00FF, 1'b1, 16'h007F);
        add_item(1'b0, 16'h0080, 1'b1, 16'h0000);
        add_item(1'b0, 16'hFF7F, 1'b1, 16'hFFFF);   // high byte ignored
        add_item(1'b0, 16'h5A81, 1'b1, 16'h0001);
        add_item(1'b0, 16'h00C0, 1'b1, 16'h0040);   // completes the sound
        add_item(1'b0, 16'h0011, 1'b0, 16'h0000);   // sound done, no output
        // zero step: the first sample hits the per-sample cap, the second reaches the total; upper data bits ignored
        add_cfg(REG_IN_WIDE, 24'hFFFFF1);
        add_cfg(REG_OUT_WIDE, 24'h000003);
        add_cfg(REG_FRAC_STEP, 24'h000000);
        add_cfg(REG_OUT_TOTAL, 24'd100);
        add_item(1'b1, 16'h8000, 1'b1, 16'h8000);
        add_item(1'b0, 16'h7FFF, 1'b1, 16'h7FFF);
        add_item(1'b0, 16'h1111, 1'b0, 16'h0000);
        // tiny step: outputs left over by the cap lag behind and follow later samples
        add_cfg(REG_FRAC_STEP, 24'd2);
        add_cfg(REG_OUT_TOTAL, 24'd200);
        add_cfg(REG_OUT_WIDE, 24'hFFFFFE);
        add_item(1'b1, 16'h8000, 1'b1, 16'hFF80);
        add_item(1'b0, 16'hFFFF, 1'b1, 16'hFFFF);
        add_item(1'b0, 16'h0100, 1'b1, 16'h0001);
        add_item(1'b0, 16'h7FFF, 1'b1, 16'h007F);
        // largest step and largest total, 8-bit in, 16-bit out
        add_cfg(REG_FRAC_STEP, 24'h00FFFF);
        add_cfg(REG_OUT_TOTAL, 24'hFFFFFF);
        add_cfg(REG_IN_WIDE, 24'd0);
        add_cfg(REG_OUT_WIDE, 24'd1);
        add_item(1'b1, 16'h0000, 1'b1, 16'h8000);
        add_item(1'b0, 16'h00FF, 1'b0, 16'h0000);
        add_item(1'b1, 16'h00FF, 1'b1, 16'h7F00);
        // fractional upsampling with a restart in the middle of a sound
        add_cfg(REG_FRAC_STEP, 24'd96);
        add_cfg(REG_OUT_TOTAL, 24'd10);
        add_cfg(REG_IN_WIDE, 24'd1);
        add_item(1'b1, 16'h1234, 1'b0, 16'h0000);
        add_item(1'b0, 16'hEDCB, 1'b0, 16'h0000);
        add_item(1'b0, 16'h0001, 1'b0, 16'h0000);
        add_item(1'b1, 16'h4321, 1'b0, 16'h0000);
        add_item(1'b0, 16'hABCD, 1'b0, 16'h0000);
    end

    // sender: reset, directed table, random phases, end of run
    initial begin
        logic [23:0] step_val;
        logic [23:0] total_val;
        logic [15:0] raw;
        logic        first;
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                // registers only change while the block is idle
                if (items_since_idle) begin
                    wait_idle();
                end
                write_reg(dir_rows[i].reg_idx, dir_rows[i].value);
            end else begin
                send_item(dir_rows[i].first, dir_rows[i].value[15:0],
                          dir_rows[i].typed, dir_rows[i].typed_sample);
            end
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_idle();
            case ($urandom_range(0, 9))
                0:       step_val = 24'($urandom_range(0, 3));   // below the usual range
                1:       step_val = 24'h00FFFF;
                2:       step_val = 24'd4;
                3:       step_val = 24'd256;
                4:       step_val = 24'($urandom);                // upper bits are dropped
                default: step_val = 24'($urandom_range(4, 600));
            endcase
            case ($urandom_range(0, 7))
                0:       total_val = 24'd0;
                1:       total_val = 24'hFFFFFF;
                2:       total_val = 24'($urandom_range(1, 8));
                default: total_val = 24'($urandom_range(20, 500));
            endcase
            // pressure phase: steady upsampling with no end to the sound
            if (ph == HOLD_PHASE) begin
                step_val  = 24'($urandom_range(32, 200));
                total_val = 24'hFFFFFF;
            end
            write_reg(REG_FRAC_STEP, step_val);
            write_reg(REG_IN_WIDE, 24'($urandom));
            write_reg(REG_OUT_WIDE, 24'($urandom));
            write_reg(REG_OUT_TOTAL, total_val);
            if (ph == HOLD_PHASE) begin
                hold_req = 1'b1;
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // mostly whole sounds; sometimes a sound carries over or restarts midway
                if (k == 0) begin
                    first = ($urandom_range(0, 7) != 0);
                end else begin
                    first = ($urandom_range(0, 24) == 0);
                end
                case ($urandom_range(0, 11))
                    0:       raw = 16'h0000;
                    1:       raw = 16'hFFFF;
                    2:       raw = 16'h8000;
                    3:       raw = 16'h7FFF;
                    4:       raw = 16'h0080;
                    5:       raw = 16'h007F;
                    default: raw = 16'($urandom);
                endcase
                send_item(first, raw, 1'b0, 16'h0000);
            end
        end

        // drain, then let any stray output show up
        s_tvalid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge aclk);
        repeat (END_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // receiver: random ready gaps, one long hold-off, field-by-field compare
    initial begin
        int          gap;
        out_sample_t got;
        out_sample_t want;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            gap = draw_gap(1);
            if (hold_req) begin
                hold_req = 1'b0;
                gap = HOLD_CYCLES;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            got = {m_tdata, m_tlast, m_tuser};
            result_count++;
            if (pending_outputs.size() == 0) begin
                report_mismatch($sformatf("output %0d with nothing predicted: sample %h",
                                          result_count, got.sample));
            end else begin
                want = pending_outputs.pop_front();
                if (got.sample !== want.sample) begin
                    report_mismatch($sformatf("output %0d sample %h, predicted %h",
                                              result_count, got.sample, want.sample));
                end
                if (got.run_last !== want.run_last) begin
                    report_mismatch($sformatf("output %0d tlast %b, predicted %b",
                                              result_count, got.run_last, want.run_last));
                end
                if (got.sound_done !== want.sound_done) begin
                    report_mismatch($sformatf("output %0d sound done %b, predicted %b",
                                              result_count, got.sound_done, want.sound_done));
                end
            end
        end
    end

    // watchdog: cycles in which nothing moves on any port
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

endmodule
